[rtl/pblru_pkg.sv]
// Shared constants and types for the page buffer frame table.
// Stand-alone package; used by the core with scoped names.
`default_nettype none

package pblru_pkg;

    // Field widths fixed by the interface.
    localparam int PAGE_W   = 64;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 5;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    // Configuration register file.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_FRAME_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 5'd16;

    // Request kinds carried on tuser.
    localparam logic FUNC_FIX   = 1'b0;
    localparam logic FUNC_UNFIX = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FULL      = 2'd1;
    localparam status_t STATUS_BAD_UNFIX = 2'd2;
    localparam status_t STATUS_PIN_SAT   = 2'd3;

endpackage

`default_nettype wire

[rtl/page_buffer_lru_pin_table_core.sv]
// Frame table core: page lookup, pin counts and least-recently-released
// replacement list. Depends on pblru_pkg for widths, codes and types.
`default_nettype none

// A fix request walks the page memory with one 64-bit comparator, one frame
// per cycle, then lets the compare stage drain, decides, updates a hit or an
// eviction and registers the result; the core is ready for the next request
// as soon as the result is registered. An unfix request does one pin-count
// memory read, one update and then registers the result. The core is
// not ready while a request is in progress; a registered result may wait
// on m_tready while the next request is accepted and worked on. There is no
// clearing pass after reset: valid bits live in flip-flops and every other
// store is read only behind a valid frame or a listed link.
module page_buffer_lru_pin_table_core #(
    parameter int FRAMES   = 16,
    parameter int PIN_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request stream. s_tdata: page_id [63:0], frame_index [67:64], zero [71:68].
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pblru_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: func [0].
    input  logic                                 s_tuser,
    // Result stream. m_tdata: frame_slot [3:0], hit [4], evicted [5],
    // evicted_page [69:6], status [71:70].
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pblru_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pblru_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pblru_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pblru_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN     = 4'd1;
    localparam logic [3:0] S_SCAN_END = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_HIT      = 4'd4;
    localparam logic [3:0] S_EVICT    = 4'd5;
    localparam logic [3:0] S_UNFIX_RD = 4'd6;
    localparam logic [3:0] S_UNFIX    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]                          state_reg, state_next;
    logic [pblru_pkg::PAGE_W-1:0]        pid_reg, pid_next;
    logic [pblru_pkg::SLOT_W-1:0]        fidx_reg, fidx_next;
    logic [IW-1:0]                       scan_idx_reg, scan_idx_next;
    logic                                cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]                       cmp_idx_reg, cmp_idx_next;
    logic                                found_reg, found_next;
    logic [IW-1:0]                       hit_idx_reg, hit_idx_next;
    logic                                free_found_reg, free_found_next;
    logic [IW-1:0]                       free_idx_reg, free_idx_next;

    logic [pblru_pkg::SLOT_W-1:0]        res_slot_reg, res_slot_next;
    logic                                res_hit_reg, res_hit_next;
    logic                                res_ev_reg, res_ev_next;
    logic [pblru_pkg::PAGE_W-1:0]        res_page_reg, res_page_next;
    pblru_pkg::status_t                  res_status_reg, res_status_next;

    logic [FRAMES-1:0]                   valid_reg, valid_next;
    logic [IW-1:0]                       head_reg, head_next;
    logic [IW-1:0]                       tail_reg, tail_next;
    logic                                nonempty_reg, nonempty_next;
    logic [pblru_pkg::LIMIT_W-1:0]       used_reg, used_next;
    logic [pblru_pkg::LIMIT_W-1:0]       limit_reg;

    logic                                out_vld_reg, out_vld_next;
    logic [pblru_pkg::OUT_TDATA_W-1:0]   out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Memories with registered read ports
    // ------------------------------------------------------------------
    logic [pblru_pkg::PAGE_W-1:0] page_mem [FRAMES];
    logic [PIN_BITS-1:0]          pin_mem  [FRAMES];
    logic [IW-1:0]                next_mem [FRAMES];
    logic [IW-1:0]                prev_mem [FRAMES];

    logic [pblru_pkg::PAGE_W-1:0] page_rd_reg;
    logic [PIN_BITS-1:0]          pin_rd_reg;
    logic [IW-1:0]                next_rd_reg;
    logic [IW-1:0]                prev_rd_reg;

    logic                         page_we, pin_we, next_we, prev_we;
    logic [IW-1:0]                page_wa, pin_wa, next_wa, prev_wa;
    logic [pblru_pkg::PAGE_W-1:0] page_wd;
    logic [PIN_BITS-1:0]          pin_wd;
    logic [IW-1:0]                next_wd, prev_wd;
    logic [IW-1:0]                page_ra, pin_ra, link_ra;

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_wa] <= page_wd;
        end
        page_rd_reg <= page_mem[page_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pin_we)
        begin
            pin_mem[pin_wa] <= pin_wd;
        end
        pin_rd_reg <= pin_mem[pin_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd_reg <= next_mem[link_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_rd_reg <= prev_mem[link_ra];
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= pblru_pkg::FRAME_LIMIT_RESET;
        end
        else if (cfg_wr && (paddr[2] == pblru_pkg::REG_FRAME_LIMIT))
        begin
            limit_reg <= pwdata[pblru_pkg::LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == pblru_pkg::REG_FRAME_LIMIT)
        begin
            prdata = pblru_pkg::CFG_DATA_W'(limit_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic          s_fire;
    logic [IW-1:0] fidx_idx;
    logic          fidx_oob;
    logic          below_limit;
    logic          pin_zero;
    logic          pin_full;

    assign s_tready    = (state_reg == S_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign fidx_idx    = IW'(fidx_reg);
    assign fidx_oob    = (32'(fidx_reg) >= FRAMES);
    assign below_limit = (used_reg < limit_reg) && (32'(used_reg) < FRAMES);
    assign pin_zero    = (pin_rd_reg == '0);
    assign pin_full    = &pin_rd_reg;

    always_comb
    begin
        state_next      = state_reg;
        pid_next        = pid_reg;
        fidx_next       = fidx_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_slot_next   = res_slot_reg;
        res_hit_next    = res_hit_reg;
        res_ev_next     = res_ev_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        valid_next      = valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        nonempty_next   = nonempty_reg;
        used_next       = used_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_data_next   = out_data_reg;

        page_we = 1'b0;
        page_wa = '0;
        page_wd = pid_reg;
        pin_we  = 1'b0;
        pin_wa  = '0;
        pin_wd  = '0;
        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        page_ra = '0;
        pin_ra  = '0;
        link_ra = '0;

        // The compare stage checks each page memory read in the cycle after it.
        if (cmp_vld_reg && !found_reg && valid_reg[cmp_idx_reg] &&
            (page_rd_reg == pid_reg))
        begin
            found_next   = 1'b1;
            hit_idx_next = cmp_idx_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    pid_next        = s_tdata[63:0];
                    fidx_next       = s_tdata[67:64];
                    scan_idx_next   = '0;
                    cmp_vld_next    = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    res_slot_next   = '0;
                    res_hit_next    = 1'b0;
                    res_ev_next     = 1'b0;
                    res_page_next   = '0;
                    res_status_next = pblru_pkg::STATUS_OK;
                    state_next      = (s_tuser == pblru_pkg::FUNC_FIX) ? S_SCAN : S_UNFIX_RD;
                end
            end

            S_SCAN:
            begin
                page_ra       = scan_idx_reg;
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + 1'b1;
                // The lowest free frame is picked up on the way.
                if (!free_found_reg && !valid_reg[scan_idx_reg])
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_idx_reg;
                end
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_SCAN_END;
                end
            end

            S_SCAN_END:
            begin
                cmp_vld_next = 1'b0;
                state_next   = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (found_reg)
                begin
                    pin_ra     = hit_idx_reg;
                    link_ra    = hit_idx_reg;
                    state_next = S_HIT;
                end
                else if (below_limit)
                begin
                    if (free_found_reg)
                    begin
                        page_we                 = 1'b1;
                        page_wa                 = free_idx_reg;
                        pin_we                  = 1'b1;
                        pin_wa                  = free_idx_reg;
                        pin_wd                  = PIN_BITS'(1);
                        valid_next[free_idx_reg] = 1'b1;
                        used_next               = used_reg + 1'b1;
                        res_slot_next           = pblru_pkg::SLOT_W'(free_idx_reg);
                    end
                    else
                    begin
                        res_status_next = pblru_pkg::STATUS_FULL;
                    end
                    state_next = S_DONE;
                end
                else if (nonempty_reg)
                begin
                    page_ra    = head_reg;
                    link_ra    = head_reg;
                    state_next = S_EVICT;
                end
                else
                begin
                    res_status_next = pblru_pkg::STATUS_FULL;
                    state_next      = S_DONE;
                end
            end

            S_HIT:
            begin
                res_slot_next = pblru_pkg::SLOT_W'(hit_idx_reg);
                res_hit_next  = 1'b1;
                if (pin_full)
                begin
                    res_status_next = pblru_pkg::STATUS_PIN_SAT;
                end
                else
                begin
                    pin_we = 1'b1;
                    pin_wa = hit_idx_reg;
                    pin_wd = pin_rd_reg + 1'b1;
                    // An unpinned resident frame sits on the list; unlink it.
                    if (pin_zero && nonempty_reg)
                    begin
                        if ((hit_idx_reg == head_reg) && (hit_idx_reg == tail_reg))
                        begin
                            nonempty_next = 1'b0;
                        end
                        else if (hit_idx_reg == head_reg)
                        begin
                            head_next = next_rd_reg;
                        end
                        else if (hit_idx_reg == tail_reg)
                        begin
                            tail_next = prev_rd_reg;
                        end
                        else
                        begin
                            next_we = 1'b1;
                            next_wa = prev_rd_reg;
                            next_wd = next_rd_reg;
                            prev_we = 1'b1;
                            prev_wa = next_rd_reg;
                            prev_wd = prev_rd_reg;
                        end
                    end
                end
                state_next = S_DONE;
            end

            S_EVICT:
            begin
                res_slot_next        = pblru_pkg::SLOT_W'(head_reg);
                res_ev_next          = 1'b1;
                res_page_next        = page_rd_reg;
                page_we              = 1'b1;
                page_wa              = head_reg;
                pin_we               = 1'b1;
                pin_wa               = head_reg;
                pin_wd               = PIN_BITS'(1);
                valid_next[head_reg] = 1'b1;
                if (head_reg == tail_reg)
                begin
                    nonempty_next = 1'b0;
                end
                else
                begin
                    head_next = next_rd_reg;
                end
                state_next = S_DONE;
            end

            S_UNFIX_RD:
            begin
                pin_ra     = fidx_idx;
                state_next = S_UNFIX;
            end

            S_UNFIX:
            begin
                res_slot_next = fidx_reg;
                if (fidx_oob || !valid_reg[fidx_idx] || pin_zero)
                begin
                    res_status_next = pblru_pkg::STATUS_BAD_UNFIX;
                end
                else
                begin
                    pin_we = 1'b1;
                    pin_wa = fidx_idx;
                    pin_wd = pin_rd_reg - 1'b1;
                    // Released for the last time: append as most recent.
                    if (pin_rd_reg == PIN_BITS'(1))
                    begin
                        if (!nonempty_reg)
                        begin
                            head_next     = fidx_idx;
                            nonempty_next = 1'b1;
                        end
                        else
                        begin
                            next_we = 1'b1;
                            next_wa = tail_reg;
                            next_wd = fidx_idx;
                            prev_we = 1'b1;
                            prev_wa = fidx_idx;
                            prev_wd = tail_reg;
                        end
                        tail_next = fidx_idx;
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {res_status_reg, res_page_reg, res_ev_reg,
                                     res_hit_reg, res_slot_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmp_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
            used_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmp_vld_reg  <= cmp_vld_next;
            valid_reg    <= valid_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            used_reg     <= used_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg        <= pid_next;
        fidx_reg       <= fidx_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_slot_reg   <= res_slot_next;
        res_hit_reg    <= res_hit_next;
        res_ev_reg     <= res_ev_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The frame count never grows past the table size.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= FRAMES)
        else $error("frames in use exceed table size");

    // A request is worked on alone: acceptance drops ready at once.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("request accepted while busy");

    // A full buffer reports nothing beyond its status.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[71:70] == pblru_pkg::STATUS_FULL)) |->
        ((m_tdata[5:0] == '0) && (m_tdata[69:6] == '0)))
        else $error("full result carries a slot or an eviction");

    // An eviction only comes from a clean miss.
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |->
        (!m_tdata[4] && (m_tdata[71:70] == pblru_pkg::STATUS_OK)))
        else $error("eviction reported with a hit or an error");

    // An unfix request never walks the page memory.
    a_unfix_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_tuser == pblru_pkg::FUNC_UNFIX)) |=> (state_reg == S_UNFIX_RD))
        else $error("unfix request took the lookup path");

endmodule

`default_nettype wire

[dv/page_buffer_lru_pin_table_core_tb.sv]
// Testbench for page_buffer_lru_pin_table_core: drives page fix and unfix requests,
// predicts every result with a frame table model of its own and checks the result stream.
// Depends on pblru_pkg and the core RTL only.
`timescale 1ns / 100ps

module page_buffer_lru_pin_table_core_tb;

    localparam int FRAMES     = 16;
    localparam int PIN_BITS   = 8;
    localparam int PIN_MAX    = (1 << PIN_BITS) - 1;
    localparam int IDLE_PCT   = 27;
    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN_WAIT = 40;
    localparam int POOL_SIZE  = 24;
    localparam logic [pblru_pkg::CFG_ADDR_W-1:0] LIMIT_ADDR =
        pblru_pkg::CFG_ADDR_W'(4 * pblru_pkg::REG_FRAME_LIMIT);

    // Packed in the same order as m_tdata, highest field first.
    typedef struct packed {
        pblru_pkg::status_t status;
        logic [63:0]        evicted_page;
        logic               evicted;
        logic               hit;
        logic [3:0]         slot;
    } frame_result_t;

    class frame_table_board;
        bit [4:0]      frame_limit;
        bit [63:0]     page_of[FRAMES];
        bit            valid[FRAMES];
        int unsigned   pins[FRAMES];
        bit [3:0]      link_next[FRAMES];
        bit [3:0]      link_prev[FRAMES];
        bit [3:0]      lru_head;
        bit [3:0]      lru_tail;
        bit            lru_nonempty;
        int unsigned   used;
        frame_result_t expected_results[$];
        int            errors;

        function new();
            frame_limit = pblru_pkg::FRAME_LIMIT_RESET;
        endfunction

        function void unlink(bit [3:0] x);
            bit [3:0] n;
            bit [3:0] p;
            n = link_next[x];
            p = link_prev[x];
            if (!lru_nonempty)
                return;
            if (x == lru_head && x == lru_tail)
                lru_nonempty = 0;
            else if (x == lru_head)
                lru_head = n;
            else if (x == lru_tail)
                lru_tail = p;
            else
            begin
                link_next[p] = n;
                link_prev[n] = p;
            end
        endfunction

        // Works out the result of one accepted request and updates the table.
        function void note_request(bit func, bit [63:0] page, bit [3:0] frame);
            frame_result_t r;
            bit            found;
            int            i;
            int unsigned   lim;
            r = '0;
            r.status = pblru_pkg::STATUS_OK;
            if (func == pblru_pkg::FUNC_FIX)
            begin
                found = 0;
                lim = (frame_limit > FRAMES) ? FRAMES : frame_limit;
                for (i = 0; i < FRAMES; i++)
                begin
                    if (!found && valid[i] && page_of[i] == page)
                    begin
                        found = 1;
                        r.slot = 4'(i);
                    end
                end
                if (found)
                begin
                    r.hit = 1;
                    if (pins[r.slot] >= PIN_MAX)
                        r.status = pblru_pkg::STATUS_PIN_SAT;
                    else
                    begin
                        if (pins[r.slot] == 0)
                            unlink(r.slot);
                        pins[r.slot]++;
                    end
                end
                else if (used < lim)
                begin
                    for (i = 0; i < FRAMES && valid[i]; i++)
                        ;
                    if (i >= FRAMES)
                        r.status = pblru_pkg::STATUS_FULL;
                    else
                    begin
                        r.slot = 4'(i);
                        valid[i] = 1;
                        page_of[i] = page;
                        pins[i] = 1;
                        used++;
                    end
                end
                else if (lru_nonempty)
                begin
                    r.slot = lru_head;
                    unlink(r.slot);
                    r.evicted = 1;
                    r.evicted_page = page_of[r.slot];
                    page_of[r.slot] = page;
                    valid[r.slot] = 1;
                    pins[r.slot] = 1;
                end
                else
                    r.status = pblru_pkg::STATUS_FULL;
                if (r.status == pblru_pkg::STATUS_FULL)
                    r.slot = 0;
            end
            else
            begin
                r.slot = frame;
                if (!valid[frame] || pins[frame] == 0)
                    r.status = pblru_pkg::STATUS_BAD_UNFIX;
                else
                begin
                    pins[frame]--;
                    if (pins[frame] == 0)
                    begin
                        // Released frames join the tail as most recently used.
                        if (!lru_nonempty)
                        begin
                            lru_head = frame;
                            lru_nonempty = 1;
                        end
                        else
                        begin
                            link_next[lru_tail] = frame;
                            link_prev[frame] = lru_tail;
                        end
                        lru_tail = frame;
                    end
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [pblru_pkg::OUT_TDATA_W-1:0] data);
            frame_result_t got;
            frame_result_t want;
            got = frame_result_t'(data);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.slot !== want.slot)
            begin
                $display("%0t: frame_slot expected %h actual %h", $time, want.slot, got.slot);
                errors++;
            end
            if (got.hit !== want.hit)
            begin
                $display("%0t: hit expected %h actual %h", $time, want.hit, got.hit);
                errors++;
            end
            if (got.evicted !== want.evicted)
            begin
                $display("%0t: evicted expected %h actual %h", $time, want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_page !== want.evicted_page)
            begin
                $display("%0t: evicted_page expected %h actual %h", $time,
                         want.evicted_page, got.evicted_page);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %h actual %h", $time, want.status, got.status);
                errors++;
            end
        endfunction

        // Random frame that currently holds a pin, or -1 if there is none.
        function int pinned_frame();
            int picks[$];
            int i;
            for (i = 0; i < FRAMES; i++)
                if (valid[i] && pins[i] != 0)
                    picks.push_back(i);
            if (picks.size() == 0)
                return -1;
            return picks[$urandom_range(picks.size() - 1)];
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    // page_id [63:0], frame_index [67:64], zero [71:68]
    logic [pblru_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                              s_tuser;   // func [0]
    logic                              m_tvalid;
    logic                              m_tready;
    // frame_slot [3:0], hit [4], evicted [5], evicted_page [69:6], status [71:70]
    logic [pblru_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [pblru_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [pblru_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [pblru_pkg::CFG_DATA_W-1:0]  prdata;
    logic                              pready;

    frame_table_board board = new;
    bit               no_idle;
    int unsigned      cycles;
    bit [63:0]        page_pool[POOL_SIZE];

    page_buffer_lru_pin_table_core #(
        .FRAMES   (FRAMES),
        .PIN_BITS (PIN_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("page_buffer_lru_pin_table_core test failed");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(bit func, bit [63:0] page, bit [3:0] frame);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, frame, page};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(func, page, frame);
        @(negedge clk);
    endtask

    task automatic fix_page(bit [63:0] page);
        send_request(pblru_pkg::FUNC_FIX, page, 4'($urandom));
    endtask

    task automatic unfix_frame(bit [3:0] frame);
        send_request(pblru_pkg::FUNC_UNFIX, {$urandom, $urandom}, frame);
    endtask

    // The limit is only changed with nothing in flight.
    task automatic write_frame_limit(bit [4:0] value);
        s_tvalid <= 0;
        while (board.expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= pblru_pkg::CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.frame_limit = value;
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic random_request();
        int f;
        if ($urandom_range(99) < 45)
        begin
            if ($urandom_range(9) == 0)
                fix_page({$urandom, $urandom});
            else
                fix_page(page_pool[$urandom_range(POOL_SIZE - 1)]);
        end
        else
        begin
            f = board.pinned_frame();
            if (f < 0 || $urandom_range(6) == 0)
                f = $urandom_range(FRAMES - 1);
            unfix_frame(4'(f));
        end
    endtask

    initial
    begin
        bit [4:0]  limits[8];
        bit [63:0] hot_page;
        int        hot_frame;
        int        i;
        int        n;

        limits = '{5'd1, 5'd5, 5'd0, 5'd20, 5'd16, 5'd3, 5'd31, 5'd12};
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = 0;
        m_tready = 0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        no_idle  = 0;
        cycles   = 0;
        for (i = 0; i < POOL_SIZE; i++)
            page_pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: hits, release order, bad unfixes, eviction, full buffer.
        fix_page(64'h0);
        fix_page(64'hFFFF_FFFF_FFFF_FFFF);
        fix_page(64'h0);
        unfix_frame(4'd0);
        unfix_frame(4'd0);
        unfix_frame(4'd0);               // count already zero
        unfix_frame(4'd15);              // frame never used
        fix_page(64'h0);                 // hit on a listed frame
        unfix_frame(4'd1);
        unfix_frame(4'd0);
        write_frame_limit(5'd2);
        fix_page(64'hA5A5_A5A5_A5A5_A5A5);
        fix_page(64'h5A5A_5A5A_5A5A_5A5A);
        fix_page(64'h1234);              // everything pinned
        write_frame_limit(5'd0);
        unfix_frame(4'd1);
        fix_page(64'h77);                // limit zero can only evict
        fix_page(64'h88);
        write_frame_limit(5'd31);        // above the frame count
        fix_page(64'h88);
        unfix_frame(4'd0);
        unfix_frame(4'd1);
        unfix_frame(4'd2);

        // Drive one frame to pin saturation and back down, without any idling.
        no_idle  = 1;
        hot_page = {$urandom, $urandom};
        fix_page(hot_page);
        hot_frame = -1;
        for (i = 0; i < FRAMES; i++)
            if (board.valid[i] && board.page_of[i] == hot_page)
                hot_frame = i;
        for (i = 0; i < PIN_MAX + 2; i++)
            fix_page(hot_page);
        for (i = 0; i < PIN_MAX + 1 && hot_frame >= 0; i++)
            unfix_frame(4'(hot_frame));
        no_idle = 0;

        for (n = 0; n < 8; n++)
        begin
            write_frame_limit(limits[n]);
            for (i = 0; i < 40; i++)
                random_request();
        end

        @(negedge clk);
        s_tvalid <= 0;
        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0)
            $display("page_buffer_lru_pin_table_core test passed");
        else
            $display("page_buffer_lru_pin_table_core test failed");
        $finish;
    end

endmodule
